// File: src/sct_pkg.sv
// Shared types and constants for the shell command tokenizer.
// Used by the lexer, the result queue, the top level and the checker. No dependencies.
package sct_pkg;

  localparam int POS_WIDTH = 16;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [RES_CNT_W-1:0] RES_ROOM_MAX = RES_CNT_W'(RES_DEPTH - 2);

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_WEND = 3'd1,
    KIND_SEMI = 3'd2,
    KIND_PIPE = 3'd3,
    KIND_ROUT = 3'd4,
    KIND_APP  = 3'd5,
    KIND_ERR  = 3'd6,
    KIND_END  = 3'd7
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_value;
    logic [15:0] position;
    logic        last;
  } res_t;

  // Results produced by one accepted byte, oldest first.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: src/sct_lexer.sv
// Lexer state machine: mode, line position and mark registers plus next-token logic.
// Depends on sct_pkg.
module sct_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  output sct_pkg::push_t    push
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_SQ    = 3'd2,
    M_DQ    = 3'd3,
    M_DQESC = 3'd4,
    M_GT    = 3'd5
  } mode_t;

  typedef struct packed {
    logic                          vld;
    sct_pkg::kind_t                kind;
    logic [7:0]                    ch;
    logic [sct_pkg::POS_WIDTH-1:0] pos;
    mode_t                         mode;
    logic                          set_mark;
    logic                          done;
  } ev_t;

  mode_t                         mode_r, mode_nxt;
  logic [sct_pkg::POS_WIDTH-1:0] line_pos_r, line_pos_nxt;
  logic [sct_pkg::POS_WIDTH-1:0] mark_r, mark_nxt;
  logic [sct_pkg::POS_WIDTH-1:0] pos_inc;
  ev_t                           e_idle, e_dq, e0, e1;
  logic                          use_e1;
  logic                          word_stop;

  function automatic logic is_blank(logic [7:0] b);
    return (b == sct_pkg::CH_SPACE) || (b >= sct_pkg::CH_TAB && b <= sct_pkg::CH_CR);
  endfunction

  function automatic ev_t mk(sct_pkg::kind_t k, logic [7:0] c,
                             logic [sct_pkg::POS_WIDTH-1:0] p, mode_t m);
    ev_t e;
    e = '0;
    e.vld = 1'b1;
    e.kind = k;
    e.ch = c;
    e.pos = p;
    e.mode = m;
    return e;
  endfunction

  function automatic ev_t lex_idle(logic [7:0] b, logic [sct_pkg::POS_WIDTH-1:0] p);
    ev_t e;
    e = '0;
    e.mode = M_IDLE;
    e.pos = p;
    if (b == sct_pkg::CH_NUL) begin
      e = mk(sct_pkg::KIND_END, sct_pkg::CH_NUL, p, M_IDLE);
      e.done = 1'b1;
    end else if (!is_blank(b)) begin
      case (b)
        sct_pkg::CH_SEMI:   e = mk(sct_pkg::KIND_SEMI, sct_pkg::CH_NUL, p, M_IDLE);
        sct_pkg::CH_PIPE:   e = mk(sct_pkg::KIND_PIPE, sct_pkg::CH_NUL, p, M_IDLE);
        sct_pkg::CH_GT: begin
          e.mode = M_GT;
          e.set_mark = 1'b1;
        end
        sct_pkg::CH_SQUOTE: e.mode = M_SQ;
        sct_pkg::CH_DQUOTE: e.mode = M_DQ;
        default:            e = mk(sct_pkg::KIND_CHAR, b, p, M_WORD);
      endcase
    end
    return e;
  endfunction

  function automatic ev_t lex_dq(logic [7:0] b, logic [sct_pkg::POS_WIDTH-1:0] p,
                                 logic [sct_pkg::POS_WIDTH-1:0] p_inc);
    ev_t e;
    e = '0;
    e.mode = M_DQ;
    e.pos = p;
    if (b == sct_pkg::CH_NUL) begin
      e = mk(sct_pkg::KIND_ERR, sct_pkg::CH_NUL, p, M_IDLE);
      e.done = 1'b1;
    end else if (b == sct_pkg::CH_DQUOTE) begin
      e = mk(sct_pkg::KIND_WEND, sct_pkg::CH_NUL, p_inc, M_IDLE);
    end else if (b == sct_pkg::CH_BSLASH) begin
      e.mode = M_DQESC;
      e.set_mark = 1'b1;
    end else begin
      e = mk(sct_pkg::KIND_CHAR, b, p, M_DQ);
    end
    return e;
  endfunction

  // Saturating increment of the line position.
  assign pos_inc = (&line_pos_r) ? line_pos_r : line_pos_r + 1'b1;

  assign e_idle = lex_idle(byte_in, line_pos_r);
  assign e_dq   = lex_dq(byte_in, line_pos_r, pos_inc);

  assign word_stop = (byte_in == sct_pkg::CH_NUL) || is_blank(byte_in) ||
                     (byte_in == sct_pkg::CH_SEMI) || (byte_in == sct_pkg::CH_PIPE) ||
                     (byte_in == sct_pkg::CH_GT) || (byte_in == sct_pkg::CH_SQUOTE) ||
                     (byte_in == sct_pkg::CH_DQUOTE);

  always_comb begin
    e0 = '0;
    e1 = '0;
    use_e1 = 1'b0;
    unique case (mode_r)
      M_WORD: begin
        if (word_stop) begin
          e0 = mk(sct_pkg::KIND_WEND, sct_pkg::CH_NUL, line_pos_r, M_IDLE);
          e1 = e_idle;
          use_e1 = 1'b1;
        end else begin
          e0 = mk(sct_pkg::KIND_CHAR, byte_in, line_pos_r, M_WORD);
        end
      end
      M_SQ: begin
        if (byte_in == sct_pkg::CH_NUL) begin
          e0 = mk(sct_pkg::KIND_ERR, sct_pkg::CH_NUL, line_pos_r, M_IDLE);
          e0.done = 1'b1;
        end else if (byte_in == sct_pkg::CH_SQUOTE) begin
          e0 = mk(sct_pkg::KIND_WEND, sct_pkg::CH_NUL, pos_inc, M_IDLE);
        end else begin
          e0 = mk(sct_pkg::KIND_CHAR, byte_in, line_pos_r, M_SQ);
        end
      end
      M_DQ: e0 = e_dq;
      M_DQESC: begin
        if (byte_in == sct_pkg::CH_DQUOTE || byte_in == sct_pkg::CH_BSLASH) begin
          e0 = mk(sct_pkg::KIND_CHAR, byte_in, line_pos_r, M_DQ);
        end else begin
          // The backslash escaped nothing, so it is kept at its own position.
          e0 = mk(sct_pkg::KIND_CHAR, sct_pkg::CH_BSLASH, mark_r, M_DQ);
          e1 = e_dq;
          use_e1 = 1'b1;
        end
      end
      M_GT: begin
        if (byte_in == sct_pkg::CH_GT) begin
          e0 = mk(sct_pkg::KIND_APP, sct_pkg::CH_NUL, mark_r, M_IDLE);
        end else begin
          e0 = mk(sct_pkg::KIND_ROUT, sct_pkg::CH_NUL, mark_r, M_IDLE);
          e1 = e_idle;
          use_e1 = 1'b1;
        end
      end
      default: e0 = e_idle;
    endcase
  end

  always_comb begin
    mode_nxt = use_e1 ? e1.mode : e0.mode;
    line_pos_nxt = (use_e1 ? e1.done : e0.done) ? '0 : pos_inc;
    mark_nxt = (use_e1 ? e1.set_mark : e0.set_mark) ? line_pos_r : mark_r;
  end

  always_comb begin
    push.n = accept ? ({1'b0, e0.vld} + {1'b0, e1.vld}) : 2'd0;
    push.r0.kind = e0.kind;
    push.r0.char_value = e0.ch;
    push.r0.position = 16'(e0.pos);
    push.r0.last = !e1.vld;
    push.r1.kind = e1.kind;
    push.r1.char_value = e1.ch;
    push.r1.position = 16'(e1.pos);
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_pos_r <= '0;
      mark_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      line_pos_r <= line_pos_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

// File: src/sct_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one per cycle.
// Depends on sct_pkg.
module sct_result_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sct_pkg::push_t push,
  input  logic           pop,
  output logic           room,
  output logic           not_empty,
  output sct_pkg::res_t  head
);

  sct_pkg::res_t                 ent_r [sct_pkg::RES_DEPTH];
  logic [sct_pkg::RES_PTR_W-1:0] wr_r, rd_r, wr_nxt, rd_nxt, wr1;
  logic [sct_pkg::RES_CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr1 = wr_r + 1'b1;
  assign room = (cnt_r <= sct_pkg::RES_ROOM_MAX);
  assign not_empty = (cnt_r != '0);
  assign head = ent_r[rd_r];

  always_comb begin
    wr_nxt = wr_r + sct_pkg::RES_PTR_W'(push.n);
    rd_nxt = rd_r + sct_pkg::RES_PTR_W'(pop);
    cnt_nxt = cnt_r + sct_pkg::RES_CNT_W'(push.n) - sct_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      ent_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      ent_r[wr1] <= push.r1;
    end
  end

endmodule

// File: src/shell_command_tokenizer_core.sv
// Each accepted byte writes its token requests into the result queue, which registers them.
// Throughput: one byte per cycle while the queue has room; a byte that yields two tokens
// (word end plus operator, for instance) writes both at once, and they leave one at a time.
// The four-entry result queue sets the rate: a byte is taken while two slots are free.
// Reset (rst_n low, synchronous): lexer idle, line position zero, queue empty.
module shell_command_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_char_value,
  output logic [15:0] out_position,
  output logic        out_last
);

  logic           accept;
  logic           room;
  sct_pkg::push_t push;
  sct_pkg::res_t  head;

  // A byte is accepted only when the queue can hold the two tokens it may cause,
  // so the lexer never has to stall in the middle of a byte.
  assign in_ready = room;
  assign accept = in_valid && room;

  // The lexer updates its mode and position registers on every accepted byte and
  // presents zero, one or two token requests to the queue in the same cycle.
  sct_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_byte_in),
    .push    (push)
  );

  // The queue separates the two sides: new bytes keep flowing while a finished
  // token waits for the consumer.
  sct_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid && out_ready),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind = head.kind;
  assign out_char_value = head.char_value;
  assign out_position = head.position;
  assign out_last = head.last;

endmodule

// File: src/sct_checker.sv
// Port-level checker for the shell command tokenizer, bound to the top level.
// Depends on sct_pkg.
module sct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_char_value,
  input logic [15:0] out_position,
  input logic        out_last
);

  // Only word characters carry a character value.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sct_pkg::KIND_CHAR |-> out_char_value == 8'd0)
    else $error("non-character token carries a character value");

  // End of line and error always close the results of their byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sct_pkg::KIND_END || out_kind == sct_pkg::KIND_ERR)
    |-> out_last)
    else $error("line end token not marked last");

  // Input only backs up when tokens are waiting.
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Reset leaves no token pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token visible after reset");

  // A stalled token holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_char_value) && $stable(out_position) && $stable(out_last))
    else $error("stalled token changed");

endmodule

bind shell_command_tokenizer_core sct_checker u_sct_checker (.*);

// File: dv/shell_command_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shell command tokenizer core: directed rows followed
// by random command lines. Depends on sct_pkg and shell_command_tokenizer_core.
module shell_command_tokenizer_core_tb;

  // A cycle with no request moving on either side counts toward this limit. The worst
  // correct stretch is a sender gap plus two result stalls.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last token, enough for any token still in flight.
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_ITEMS = 450;
  localparam sct_pkg::res_t NO_TOK = '0;

  // Lexer modes of the predictor.
  typedef enum logic [2:0] {
    LX_IDLE, LX_WORD, LX_SQUOTE, LX_DQUOTE, LX_DQESC, LX_GT
  } lex_mode_t;

  // One directed row. A count of -1 means the predictor supplies the tokens.
  typedef struct {
    logic [7:0]    ch;
    int            n;
    sct_pkg::res_t r0;
    sct_pkg::res_t r1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_char_value;
  logic [15:0] out_position;
  logic        out_last;

  // Predictor state.
  lex_mode_t                     lx_mode = LX_IDLE;
  logic [sct_pkg::POS_WIDTH-1:0] lx_pos = '0;
  logic [sct_pkg::POS_WIDTH-1:0] lx_mark = '0;
  bit                            lx_line_closed;
  sct_pkg::res_t                 step_toks[$];

  // Tokens still owed by the block, oldest first.
  sct_pkg::res_t pending_tokens[$];
  int            fail_count = 0;
  // When set, neither side idles, so the block runs at full rate.
  bit            calm = 1'b0;
  int            items_sent = 0;

  dir_row_t dir_rows[26];

  shell_command_tokenizer_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_char_value (out_char_value),
    .out_position   (out_position),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  function automatic sct_pkg::res_t tok(sct_pkg::kind_t k, logic [7:0] c, logic [15:0] p,
                                        logic l);
    sct_pkg::res_t r;
    r.kind = k;
    r.char_value = c;
    r.position = p;
    r.last = l;
    return r;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == sct_pkg::CH_SPACE || (b >= sct_pkg::CH_TAB && b <= sct_pkg::CH_CR);
  endfunction

  // The position counter holds at its maximum instead of wrapping.
  function automatic logic [sct_pkg::POS_WIDTH-1:0] pos_after(
      logic [sct_pkg::POS_WIDTH-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  // At most two tokens come out of one byte; anything beyond is dropped.
  function automatic void emit(sct_pkg::kind_t k, logic [7:0] c,
                               logic [sct_pkg::POS_WIDTH-1:0] p);
    if (step_toks.size() < 2) step_toks.push_back(tok(k, c, 16'(p), 1'b0));
  endfunction

  // End of line and error both return the lexer to idle at position zero.
  function automatic void close_line(sct_pkg::kind_t k);
    emit(k, 8'h00, lx_pos);
    lx_mode = LX_IDLE;
    lx_pos = '0;
    lx_line_closed = 1'b1;
  endfunction

  function automatic void lex_from_idle(logic [7:0] b);
    if (b == sct_pkg::CH_NUL) begin
      close_line(sct_pkg::KIND_END);
    end else if (is_blank(b)) begin
    end else if (b == sct_pkg::CH_SEMI) begin
      emit(sct_pkg::KIND_SEMI, 8'h00, lx_pos);
    end else if (b == sct_pkg::CH_PIPE) begin
      emit(sct_pkg::KIND_PIPE, 8'h00, lx_pos);
    end else if (b == sct_pkg::CH_GT) begin
      lx_mode = LX_GT;
      lx_mark = lx_pos;
    end else if (b == sct_pkg::CH_SQUOTE) begin
      lx_mode = LX_SQUOTE;
    end else if (b == sct_pkg::CH_DQUOTE) begin
      lx_mode = LX_DQUOTE;
    end else begin
      emit(sct_pkg::KIND_CHAR, b, lx_pos);
      lx_mode = LX_WORD;
    end
  endfunction

  function automatic void lex_in_dquote(logic [7:0] b);
    if (b == sct_pkg::CH_NUL) begin
      close_line(sct_pkg::KIND_ERR);
    end else if (b == sct_pkg::CH_DQUOTE) begin
      emit(sct_pkg::KIND_WEND, 8'h00, pos_after(lx_pos));
      lx_mode = LX_IDLE;
    end else if (b == sct_pkg::CH_BSLASH) begin
      lx_mode = LX_DQESC;
      lx_mark = lx_pos;
    end else begin
      emit(sct_pkg::KIND_CHAR, b, lx_pos);
    end
  endfunction

  // Advances the predictor by one byte and leaves its tokens in step_toks.
  function automatic void lex_byte(logic [7:0] b);
    step_toks.delete();
    lx_line_closed = 1'b0;
    case (lx_mode)
      LX_WORD: begin
        if (b == sct_pkg::CH_NUL || is_blank(b) || b == sct_pkg::CH_SEMI ||
            b == sct_pkg::CH_PIPE || b == sct_pkg::CH_GT ||
            b == sct_pkg::CH_SQUOTE || b == sct_pkg::CH_DQUOTE) begin
          emit(sct_pkg::KIND_WEND, 8'h00, lx_pos);
          lx_mode = LX_IDLE;
          lex_from_idle(b);
        end else begin
          emit(sct_pkg::KIND_CHAR, b, lx_pos);
        end
      end
      LX_SQUOTE: begin
        if (b == sct_pkg::CH_NUL) begin
          close_line(sct_pkg::KIND_ERR);
        end else if (b == sct_pkg::CH_SQUOTE) begin
          emit(sct_pkg::KIND_WEND, 8'h00, pos_after(lx_pos));
          lx_mode = LX_IDLE;
        end else begin
          emit(sct_pkg::KIND_CHAR, b, lx_pos);
        end
      end
      LX_DQUOTE: lex_in_dquote(b);
      LX_DQESC: begin
        lx_mode = LX_DQUOTE;
        if (b == sct_pkg::CH_DQUOTE || b == sct_pkg::CH_BSLASH) begin
          emit(sct_pkg::KIND_CHAR, b, lx_pos);
        end else begin
          // Any other escape keeps the backslash at its own position.
          emit(sct_pkg::KIND_CHAR, sct_pkg::CH_BSLASH, lx_mark);
          lex_in_dquote(b);
        end
      end
      LX_GT: begin
        lx_mode = LX_IDLE;
        if (b == sct_pkg::CH_GT) begin
          emit(sct_pkg::KIND_APP, 8'h00, lx_mark);
        end else begin
          emit(sct_pkg::KIND_ROUT, 8'h00, lx_mark);
          lex_from_idle(b);
        end
      end
      default: begin
        lx_mode = LX_IDLE;
        lex_from_idle(b);
      end
    endcase
    if (!lx_line_closed) lx_pos = pos_after(lx_pos);
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // Sends one request, then records the tokens it owes. Typed rows override the
  // predicted tokens, but the predictor still steps so its state stays in line.
  task automatic push_byte(logic [7:0] b, int typed_n = -1, sct_pkg::res_t r0 = NO_TOK,
                           sct_pkg::res_t r1 = NO_TOK);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    lex_byte(b);
    if (typed_n >= 0) begin
      step_toks.delete();
      if (typed_n > 0) step_toks.push_back(r0);
      if (typed_n > 1) step_toks.push_back(r1);
    end
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    items_sent++;
  endtask

  // A byte that may sit inside a plain word.
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_blank(b) || b == sct_pkg::CH_SEMI || b == sct_pkg::CH_PIPE ||
           b == sct_pkg::CH_GT || b == sct_pkg::CH_SQUOTE || b == sct_pkg::CH_DQUOTE);
    return b;
  endfunction

  // A byte that is plain text inside double quotes.
  function automatic logic [7:0] dq_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == sct_pkg::CH_DQUOTE || b == sct_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    int pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? sct_pkg::CH_SPACE : sct_pkg::CH_TAB + 8'(pick);
  endfunction

  // Builds one command line out of words, quoted text and operators. A few lines carry
  // a random byte or leave a quote open, so broken input is mixed in.
  task automatic send_random_line();
    logic [7:0] line_bytes[$];
    logic [7:0] b;
    int pieces;
    int len;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 4);
          repeat (len) line_bytes.push_back(word_byte());
        end
        3: begin
          line_bytes.push_back(sct_pkg::CH_SQUOTE);
          len = $urandom_range(0, 3);
          repeat (len) begin
            do b = 8'($urandom_range(1, 255)); while (b == sct_pkg::CH_SQUOTE);
            line_bytes.push_back(b);
          end
          if ($urandom_range(0, 7) != 0) line_bytes.push_back(sct_pkg::CH_SQUOTE);
        end
        4: begin
          line_bytes.push_back(sct_pkg::CH_DQUOTE);
          len = $urandom_range(0, 4);
          repeat (len) begin
            case ($urandom_range(0, 3))
              0: begin
                line_bytes.push_back(sct_pkg::CH_BSLASH);
                line_bytes.push_back(sct_pkg::CH_DQUOTE);
              end
              1: begin
                line_bytes.push_back(sct_pkg::CH_BSLASH);
                line_bytes.push_back(sct_pkg::CH_BSLASH);
              end
              2: begin
                line_bytes.push_back(sct_pkg::CH_BSLASH);
                line_bytes.push_back(dq_byte());
              end
              default: line_bytes.push_back(dq_byte());
            endcase
          end
          if ($urandom_range(0, 7) == 0) begin
            // Leave the quote open, sometimes right after a backslash.
            if ($urandom_range(0, 1) == 0) line_bytes.push_back(sct_pkg::CH_BSLASH);
          end else begin
            line_bytes.push_back(sct_pkg::CH_DQUOTE);
          end
        end
        5: line_bytes.push_back(sct_pkg::CH_SEMI);
        6: line_bytes.push_back(sct_pkg::CH_PIPE);
        7: line_bytes.push_back(sct_pkg::CH_GT);
        8: begin
          line_bytes.push_back(sct_pkg::CH_GT);
          line_bytes.push_back(sct_pkg::CH_GT);
        end
        default: begin
          len = $urandom_range(1, 3);
          repeat (len) line_bytes.push_back(blank_byte());
        end
      endcase
      if ($urandom_range(0, 2) == 0) line_bytes.push_back(blank_byte());
      if ($urandom_range(0, 9) == 0) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    line_bytes.push_back(sct_pkg::CH_NUL);
    foreach (line_bytes[i]) push_byte(line_bytes[i]);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: stalls a random number of cycles before each token, then takes it and
  // checks it against the oldest token still owed.
  initial begin
    int stall;
    sct_pkg::res_t want;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: kind %0d, char %0d, position %0d, last %0d",
                 $time, out_kind, out_char_value, out_position, out_last);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("char_value", want.char_value, out_char_value);
        check_field("position", want.position, out_position);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout with %0d tokens outstanding", $time, pending_tokens.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // Directed rows. Tokens are typed in where they can be read off directly: the end
    // of line straight out of reset, the top byte value, and the error and end codes.
    dir_rows = '{
      '{sct_pkg::CH_NUL, 1, tok(sct_pkg::KIND_END, 8'h00, 16'd0, 1'b1), NO_TOK},
      '{8'h61, -1, NO_TOK, NO_TOK},
      '{8'hFF, 1, tok(sct_pkg::KIND_CHAR, 8'hFF, 16'd1, 1'b1), NO_TOK},
      '{sct_pkg::CH_SEMI, -1, NO_TOK, NO_TOK},    // word end plus semicolon
      '{sct_pkg::CH_PIPE, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_GT, -1, NO_TOK, NO_TOK},      // held until the next byte
      '{sct_pkg::CH_GT, -1, NO_TOK, NO_TOK},      // append
      '{sct_pkg::CH_GT, -1, NO_TOK, NO_TOK},
      '{8'h62, -1, NO_TOK, NO_TOK},               // redirect out, then a word starts
      '{sct_pkg::CH_CR, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_SQUOTE, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_SQUOTE, -1, NO_TOK, NO_TOK},  // empty quotes still end a word
      '{sct_pkg::CH_DQUOTE, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_BSLASH, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_DQUOTE, -1, NO_TOK, NO_TOK},  // escaped double quote
      '{sct_pkg::CH_BSLASH, -1, NO_TOK, NO_TOK},
      '{8'h78, -1, NO_TOK, NO_TOK},               // backslash kept at its own position
      '{sct_pkg::CH_DQUOTE, -1, NO_TOK, NO_TOK},
      '{8'h63, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_SQUOTE, -1, NO_TOK, NO_TOK},  // quote inside a word opens a quote
      '{sct_pkg::CH_NUL, 1, tok(sct_pkg::KIND_ERR, 8'h00, 16'd19, 1'b1), NO_TOK},
      '{sct_pkg::CH_DQUOTE, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_BSLASH, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_NUL, 2, tok(sct_pkg::KIND_CHAR, sct_pkg::CH_BSLASH, 16'd1, 1'b0),
                            tok(sct_pkg::KIND_ERR, 8'h00, 16'd2, 1'b1)},
      '{sct_pkg::CH_GT, -1, NO_TOK, NO_TOK},
      '{sct_pkg::CH_NUL, 2, tok(sct_pkg::KIND_ROUT, 8'h00, 16'd0, 1'b0),
                            tok(sct_pkg::KIND_END, 8'h00, 16'd1, 1'b1)}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_byte(dir_rows[i].ch, dir_rows[i].n, dir_rows[i].r0,
                                    dir_rows[i].r1);

    // Random command lines; some run with no idling on either side.
    while (items_sent < TOTAL_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      send_random_line();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
